### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the six-bit card machine.
// Depends on nothing; files that assert include it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbc assertion failed");

`endif

### hw/rtl/sbc_pkg.sv
// Package for the six-bit card machine: widths, control bit positions,
// reset values, mode and state codes. Depends on nothing.
`default_nettype none

package sbc_pkg;

  // Memory geometry.
  localparam int MEM_DEPTH = 262144;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // Field widths.
  localparam int ADDR_W = 18;
  localparam int CTRL_W = 8;
  localparam int DATA_W = 6;
  localparam int KEY_W  = 7;
  localparam int CHAR_W = 7;

  // Reciprocal of the depth for the address reduction; the quotient it
  // gives is exact or one too small.
  localparam int              RECIP_SH = 36;
  localparam longint unsigned RECIP    = (64'd1 << RECIP_SH) / MEM_DEPTH;
  localparam int              RECIP_W  = $clog2(RECIP + 1);
  localparam int              QUO_W    = ADDR_W - MEM_AW + 1;

  // Control bit positions; a bit at zero is active.
  localparam int BIT_IO  = 7;
  localparam int BIT_PTR = 6;
  localparam int BIT_RET = 5;
  localparam int BIT_ST  = 4;
  localparam int BIT_LD  = 3;
  localparam int BIT_LDH = 2;
  localparam int BIT_LDM = 1;
  localparam int BIT_LDL = 0;

  // Reset values.
  localparam logic [CTRL_W-1:0] CTRL_RESET     = 8'hFF;
  localparam logic [CTRL_W-1:0] CTRL_MEM_RESET = 8'd231;
  localparam logic [DATA_W-1:0] KEY_NONE       = 6'h3F;

  // Six-bit character codes with special meaning.
  localparam logic [DATA_W-1:0] CODE_NEWLINE = 6'd61;
  localparam logic [DATA_W-1:0] CODE_RETURN  = 6'd62;
  localparam logic [DATA_W-1:0] CODE_NULL    = 6'd63;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_RUN  = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_KEY  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SLOT  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/six_bit_card_cpu_cycle_unit.sv
// Top level of the six-bit card machine: sequencer, registers, address
// reduction and the machine memory. Uses sbc_pkg, sbc_ram, assert_macros.svh.
//
//   channel   direction  handshake        ports
//   request   in         start / busy     mode_i, load_*_i, key_ascii_i
//   result    out        valid_o strobe   print_valid_o, print_char_o,
//                                         fetch_address_o
//
// A run request passes ST_SLOT and ST_DONE: the address and its quotient are formed on
// acceptance, the memory word is read in the next cycle (ST_SLOT), and in ST_DONE the
// registers take the read word while the modified word is written back.
// A load request writes its word in ST_SLOT; key and unused requests are answered from ST_IDLE.
// Each result shows for one cycle after the last cycle; the receiver cannot stall.
// After reset the memory is cleared one entry a cycle, over all entries, busy high.
`default_nettype none
`include "assert_macros.svh"

module six_bit_card_cpu_cycle_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   mode_i,
  input  wire logic [sbc_pkg::ADDR_W-1:0]   load_address_i,
  input  wire logic [sbc_pkg::CTRL_W-1:0]   load_control_i,
  input  wire logic [sbc_pkg::ADDR_W-1:0]   load_next_i,
  input  wire logic [sbc_pkg::ADDR_W-1:0]   load_return_i,
  input  wire logic [sbc_pkg::DATA_W-1:0]   load_value_i,
  input  wire logic [sbc_pkg::KEY_W-1:0]    key_ascii_i,
  output logic                              valid_o,
  output logic                              print_valid_o,
  output logic      [sbc_pkg::CHAR_W-1:0]   print_char_o,
  output logic      [sbc_pkg::ADDR_W-1:0]   fetch_address_o
);

  localparam int PROD_W = sbc_pkg::ADDR_W + sbc_pkg::RECIP_W;
  localparam int REM_W  = sbc_pkg::ADDR_W + 1;
  localparam int MEM_W  = sbc_pkg::CTRL_W + 2 * sbc_pkg::ADDR_W + sbc_pkg::DATA_W;
  localparam logic [REM_W-1:0]               DEPTH_V    = REM_W'(sbc_pkg::MEM_DEPTH);
  localparam logic [sbc_pkg::MEM_AW-1:0]     CLEAR_LAST = sbc_pkg::MEM_AW'(sbc_pkg::MEM_DEPTH - 1);
  localparam logic [PROD_W-1:0]              RECIP_V    = PROD_W'(sbc_pkg::RECIP);

  // ASCII codes used by the key and print translations.
  localparam logic [sbc_pkg::KEY_W-1:0]  ASCII_NUL   = 7'd0;
  localparam logic [sbc_pkg::KEY_W-1:0]  ASCII_LF    = 7'd10;
  localparam logic [sbc_pkg::KEY_W-1:0]  ASCII_CR    = 7'd13;
  localparam logic [sbc_pkg::KEY_W-1:0]  ASCII_SPACE = 7'd32;
  localparam logic [sbc_pkg::KEY_W-1:0]  ASCII_ULINE = 7'd95;
  localparam logic [sbc_pkg::KEY_W-1:0]  ASCII_LC_A  = 7'd97;
  localparam logic [sbc_pkg::KEY_W-1:0]  ASCII_LC_Z  = 7'd122;
  localparam logic [sbc_pkg::KEY_W-1:0]  LC_OFFSET   = 7'd64;

  typedef struct packed {
    logic                        hit;
    logic [sbc_pkg::DATA_W-1:0]  code;
  } key_upd_t;

  // Translate a typed ASCII key into the six-bit code.
  function automatic key_upd_t key_xlate(logic [sbc_pkg::KEY_W-1:0] k);
    key_upd_t r;
    r.hit  = 1'b1;
    r.code = sbc_pkg::KEY_NONE;
    if (k == ASCII_NUL) begin
      r.hit = 1'b0;
    end else if (k == ASCII_LF || k == ASCII_CR) begin
      r.code = sbc_pkg::CODE_NEWLINE;
    end else if (k < ASCII_SPACE) begin
      r.code = sbc_pkg::CODE_RETURN;
    end else if (k <= ASCII_ULINE) begin
      r.code = sbc_pkg::DATA_W'(k - ASCII_SPACE);
    end else if (k >= ASCII_LC_A && k <= ASCII_LC_Z) begin
      r.code = sbc_pkg::DATA_W'(k - LC_OFFSET);
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  // Translate a six-bit code into the printed ASCII character.
  function automatic logic [sbc_pkg::CHAR_W-1:0] print_code(logic [sbc_pkg::DATA_W-1:0] c);
    logic [sbc_pkg::CHAR_W-1:0] r;
    unique case (c)
      sbc_pkg::CODE_NEWLINE: r = ASCII_LF;
      sbc_pkg::CODE_RETURN:  r = ASCII_CR;
      sbc_pkg::CODE_NULL:    r = ASCII_NUL;
      default:               r = sbc_pkg::CHAR_W'(c) + ASCII_SPACE;
    endcase
    return r;
  endfunction

  // Sequencer and architectural registers.
  sbc_pkg::state_e              state_q, state_d;
  logic [sbc_pkg::MEM_AW-1:0]   clr_q, clr_d;
  logic [sbc_pkg::CTRL_W-1:0]   ctrl_q, ctrl_d;
  logic [sbc_pkg::ADDR_W-1:0]   next_q, next_d;
  logic [sbc_pkg::ADDR_W-1:0]   ret_q, ret_d;
  logic [sbc_pkg::DATA_W-1:0]   data_q, data_d;
  logic [sbc_pkg::DATA_W-1:0]   high_q, high_d;
  logic [sbc_pkg::DATA_W-1:0]   mid_q, mid_d;
  logic [sbc_pkg::DATA_W-1:0]   low_q, low_d;
  logic [sbc_pkg::DATA_W-1:0]   key_q, key_d;
  logic                         run_q, run_d;
  logic                         fwd_next_q, fwd_next_d;
  logic                         fwd_data_q, fwd_data_d;

  // Request payload held across the cycles of one request.
  logic [sbc_pkg::ADDR_W-1:0]   addr_q, addr_d;
  logic [sbc_pkg::QUO_W-1:0]    quo_q, quo_d;
  logic [sbc_pkg::CTRL_W-1:0]   ld_ctrl_q, ld_ctrl_d;
  logic [sbc_pkg::ADDR_W-1:0]   ld_next_q, ld_next_d;
  logic [sbc_pkg::ADDR_W-1:0]   ld_ret_q, ld_ret_d;
  logic [sbc_pkg::DATA_W-1:0]   ld_data_q, ld_data_d;

  // Result registers.
  logic                         valid_q, valid_d;
  logic                         pvalid_q, pvalid_d;
  logic [sbc_pkg::CHAR_W-1:0]   pchar_q, pchar_d;
  logic [sbc_pkg::ADDR_W-1:0]   faddr_q, faddr_d;

  // Memory port and the fields of the stored word.
  logic [sbc_pkg::MEM_AW-1:0]   ram_addr;
  logic                         mem_we;
  logic [MEM_W-1:0]             mem_wd, mem_rd;
  logic [sbc_pkg::CTRL_W-1:0]   ctrl_rd;
  logic [sbc_pkg::ADDR_W-1:0]   next_rd;
  logic [sbc_pkg::ADDR_W-1:0]   ret_rd;
  logic [sbc_pkg::DATA_W-1:0]   data_rd;

  // Address path.
  logic [sbc_pkg::ADDR_W-1:0]   run_addr, addr_in;
  logic [PROD_W-1:0]            prod;
  logic [REM_W-1:0]             rem_full, slot_sel;
  logic                         run_next_we, run_data_we;
  logic                         accept;
  logic                         short_req;
  key_upd_t                     key_upd;
  logic [sbc_pkg::ADDR_W-1:0]   next_val;
  logic [sbc_pkg::DATA_W-1:0]   dmem_val;

  assign busy      = (state_q != sbc_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign short_req = accept && (mode_i == sbc_pkg::MODE_KEY || mode_i == sbc_pkg::MODE_NONE);

  // Address of a run cycle: pointer registers or the next register.
  assign run_addr = ctrl_q[sbc_pkg::BIT_PTR] ? next_q : {high_q, mid_q, low_q};
  assign addr_in  = (mode_i == sbc_pkg::MODE_LOAD) ? load_address_i : run_addr;

  // Quotient estimate of the address by the depth, registered on acceptance.
  assign prod = PROD_W'(addr_in) * RECIP_V;

  // Remainder with one correction step gives the memory entry.
  assign rem_full = {1'b0, addr_q} - REM_W'(quo_q) * DEPTH_V;
  assign slot_sel = (rem_full >= DEPTH_V) ? rem_full - DEPTH_V : rem_full;

  // Write phase of a run cycle under the current control word.
  assign run_next_we = !ctrl_q[sbc_pkg::BIT_RET];
  assign run_data_we = !ctrl_q[sbc_pkg::BIT_ST] && ctrl_q[sbc_pkg::BIT_IO];

  assign key_upd = key_xlate(key_ascii_i);

  assign {ctrl_rd, next_rd, ret_rd, data_rd} = mem_rd;

  // Read data, with the value written in the same cycle forwarded.
  assign next_val = fwd_next_q ? ret_q : next_rd;
  assign dmem_val = fwd_data_q ? data_q : data_rd;

  // Memory port control: clearing pass, load, or write-back of a run cycle.
  // A run with a write phase writes back the word it read, with that phase applied.
  always_comb begin
    ram_addr = sbc_pkg::MEM_AW'(slot_sel);
    mem_we   = 1'b0;
    mem_wd   = {ld_ctrl_q, ld_next_q, ld_ret_q, ld_data_q};
    if (state_q == sbc_pkg::ST_CLEAR) begin
      ram_addr = clr_q;
      mem_we   = 1'b1;
      mem_wd   = {sbc_pkg::CTRL_MEM_RESET, {sbc_pkg::ADDR_W{1'b0}},
                  {sbc_pkg::ADDR_W{1'b0}}, {sbc_pkg::DATA_W{1'b0}}};
    end else if (state_q == sbc_pkg::ST_SLOT) begin
      mem_we = !run_q;
    end else if (state_q == sbc_pkg::ST_DONE) begin
      mem_we = fwd_next_q || fwd_data_q;
      mem_wd = {ctrl_rd, next_val, ret_rd, dmem_val};
    end
  end

  // Sequencer and register updates.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    ctrl_d     = ctrl_q;
    next_d     = next_q;
    ret_d      = ret_q;
    data_d     = data_q;
    high_d     = high_q;
    mid_d      = mid_q;
    low_d      = low_q;
    key_d      = key_q;
    run_d      = run_q;
    fwd_next_d = fwd_next_q;
    fwd_data_d = fwd_data_q;
    addr_d     = addr_q;
    quo_d      = quo_q;
    ld_ctrl_d  = ld_ctrl_q;
    ld_next_d  = ld_next_q;
    ld_ret_d   = ld_ret_q;
    ld_data_d  = ld_data_q;
    valid_d    = 1'b0;
    pvalid_d   = 1'b0;
    pchar_d    = pchar_q;
    faddr_d    = faddr_q;

    unique case (state_q)
      sbc_pkg::ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == CLEAR_LAST) begin
          state_d = sbc_pkg::ST_IDLE;
        end
      end

      sbc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            sbc_pkg::MODE_RUN: begin
              addr_d  = addr_in;
              quo_d   = sbc_pkg::QUO_W'(prod >> sbc_pkg::RECIP_SH);
              run_d   = 1'b1;
              state_d = sbc_pkg::ST_SLOT;
            end
            sbc_pkg::MODE_LOAD: begin
              addr_d    = addr_in;
              quo_d     = sbc_pkg::QUO_W'(prod >> sbc_pkg::RECIP_SH);
              run_d     = 1'b0;
              ld_ctrl_d = load_control_i;
              ld_next_d = load_next_i;
              ld_ret_d  = load_return_i;
              ld_data_d = load_value_i;
              state_d   = sbc_pkg::ST_SLOT;
            end
            sbc_pkg::MODE_KEY: begin
              if (key_upd.hit) begin
                key_d = key_upd.code;
              end
              valid_d = 1'b1;
              pchar_d = '0;
              faddr_d = '0;
            end
            default: begin
              valid_d = 1'b1;
              pchar_d = '0;
              faddr_d = '0;
            end
          endcase
        end
      end

      sbc_pkg::ST_SLOT: begin
        fwd_next_d = run_next_we;
        fwd_data_d = run_data_we;
        if (run_q) begin
          state_d = sbc_pkg::ST_DONE;
        end else begin
          valid_d = 1'b1;
          pchar_d = '0;
          faddr_d = '0;
          state_d = sbc_pkg::ST_IDLE;
        end
      end

      sbc_pkg::ST_DONE: begin
        // Print under the old control word, then take the fetched words.
        valid_d  = 1'b1;
        pvalid_d = !ctrl_q[sbc_pkg::BIT_ST] && !ctrl_q[sbc_pkg::BIT_IO];
        pchar_d  = pvalid_d ? print_code(data_q) : '0;
        faddr_d  = addr_q;
        ctrl_d   = ctrl_rd;
        next_d   = next_val;
        ret_d    = ret_rd;
        if (!ctrl_rd[sbc_pkg::BIT_LD]) begin
          if (!ctrl_rd[sbc_pkg::BIT_IO]) begin
            data_d = key_q;
            key_d  = sbc_pkg::KEY_NONE;
          end else begin
            data_d = dmem_val;
          end
        end
        if (!ctrl_rd[sbc_pkg::BIT_LDH]) begin
          high_d = dmem_val;
        end
        if (!ctrl_rd[sbc_pkg::BIT_LDM]) begin
          mid_d = dmem_val;
        end
        if (!ctrl_rd[sbc_pkg::BIT_LDL]) begin
          low_d = dmem_val;
        end
        state_d = sbc_pkg::ST_IDLE;
      end

      default: begin
        state_d = sbc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sbc_pkg::ST_CLEAR;
      clr_q      <= '0;
      ctrl_q     <= sbc_pkg::CTRL_RESET;
      next_q     <= '0;
      ret_q      <= '0;
      data_q     <= '0;
      high_q     <= '0;
      mid_q      <= '0;
      low_q      <= '0;
      key_q      <= sbc_pkg::KEY_NONE;
      run_q      <= 1'b0;
      fwd_next_q <= 1'b0;
      fwd_data_q <= 1'b0;
      valid_q    <= 1'b0;
      pvalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      ctrl_q     <= ctrl_d;
      next_q     <= next_d;
      ret_q      <= ret_d;
      data_q     <= data_d;
      high_q     <= high_d;
      mid_q      <= mid_d;
      low_q      <= low_d;
      key_q      <= key_d;
      run_q      <= run_d;
      fwd_next_q <= fwd_next_d;
      fwd_data_q <= fwd_data_d;
      valid_q    <= valid_d;
      pvalid_q   <= pvalid_d;
    end
  end

  // Request payload and result fields.
  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    quo_q     <= quo_d;
    ld_ctrl_q <= ld_ctrl_d;
    ld_next_q <= ld_next_d;
    ld_ret_q  <= ld_ret_d;
    ld_data_q <= ld_data_d;
    pchar_q   <= pchar_d;
    faddr_q   <= faddr_d;
  end

  assign valid_o         = valid_q;
  assign print_valid_o   = pvalid_q;
  assign print_char_o    = pchar_q;
  assign fetch_address_o = faddr_q;

  // One memory holds the control, next, return and data words of each entry.
  sbc_ram #(.Width(MEM_W), .Depth(sbc_pkg::MEM_DEPTH)) u_mem_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (ram_addr),
    .wdata_i (mem_wd),
    .rdata_o (mem_rd)
  );

  // No result may appear while the memory is being cleared.
  `SBC_ASSERT_IMPLY(a_no_result_in_clear, clk_i, rst_ni, valid_o, state_q != sbc_pkg::ST_CLEAR)

  // Key and unused requests answer in the next cycle.
  `SBC_ASSERT_NEXT(a_short_req_result, clk_i, rst_ni, short_req, valid_o)

  // The last cycle of a run request always delivers its result.
  `SBC_ASSERT_NEXT(a_run_result, clk_i, rst_ni, state_q == sbc_pkg::ST_DONE, valid_o && !busy)

  // The reduced address always lies inside the memory.
  `SBC_ASSERT_IMPLY(a_slot_in_range, clk_i, rst_ni, state_q == sbc_pkg::ST_SLOT, slot_sel < DEPTH_V)

endmodule

`default_nettype wire

### hw/rtl/sbc_ram.sv
// Generic single-port synchronous RAM with a registered, read-first port.
// Depends on nothing.
`default_nettype none

module sbc_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and read the same entry; the read returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
